/* rtl/core/dual_down_counter_timer_macros.svh */
// ----------------------------------------------------------------------------
// Dual down-counter timer assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_DOWN_COUNTER_TIMER_MACROS_SVH
`define DUAL_DOWN_COUNTER_TIMER_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define DDCT_ASSERT_ON(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A consequent that must follow whenever the antecedent holds.
`define DDCT_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

`endif

/* rtl/core/ddct_pkg.sv */
// ----------------------------------------------------------------------------
// Dual down-counter timer package
// Widths, command and register codes, control bit positions and helpers.
// ----------------------------------------------------------------------------
package ddct_pkg;

  localparam int unsigned NUM_TIMERS    = 2;
  localparam int unsigned COUNTER_WIDTH = 32;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned OFFSET_W   = 6;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CTRL_W     = 8;
  localparam int unsigned PRESCALE_W = 8;

  // Offset decode: bit 5 picks the timer, bits 4..2 the register.
  localparam int unsigned TIMER_SEL_BIT = 5;
  localparam int unsigned REG_MSB       = 4;
  localparam int unsigned REG_LSB       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_LOAD    = 3'd0,
    REG_VALUE   = 3'd1,
    REG_CONTROL = 3'd2,
    REG_INTCLR  = 3'd3,
    REG_RIS     = 3'd4,
    REG_MIS     = 3'd5,
    REG_BGLOAD  = 3'd6
  } reg_e;

  // Control register bit positions.
  localparam int unsigned CTL_ONESHOT  = 0;
  localparam int unsigned CTL_SIZE32   = 1;
  localparam int unsigned CTL_PSC_LSB  = 2;
  localparam int unsigned CTL_PSC_MSB  = 3;
  localparam int unsigned CTL_IE       = 5;
  localparam int unsigned CTL_PERIODIC = 6;
  localparam int unsigned CTL_ENABLE   = 7;

  localparam logic [CTRL_W-1:0] CTL_WRITABLE = 8'hEF;
  localparam logic [CTRL_W-1:0] CTL_RESET    = 8'h20;

  typedef enum logic [1:0] {
    PSC_DIV1   = 2'd0,
    PSC_DIV16  = 2'd1,
    PSC_DIV256 = 2'd2
  } psc_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   write_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_zero;
    logic              irq_one;
    logic              irq_either;
  } out_item_t;

  // Last prescaler count before the counter steps (divisor less one).
  function automatic logic [PRESCALE_W-1:0] prescale_last(input logic [1:0] code);
    logic [PRESCALE_W-1:0] last;
    case (code)
      PSC_DIV16:  last = 8'd15;
      PSC_DIV256: last = 8'd255;
      default:    last = 8'd0;
    endcase
    return last;
  endfunction

endpackage

/* rtl/core/ddct_if.sv */
// ----------------------------------------------------------------------------
// Dual down-counter timer channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface ddct_in_if;
  logic                             valid;
  logic                             ready;
  logic [ddct_pkg::CMD_W-1:0]       cmd;
  logic [ddct_pkg::OFFSET_W-1:0]    offset;
  logic [ddct_pkg::DATA_W-1:0]      write_data;

  modport source (output valid, output cmd, output offset, output write_data, input ready);
  modport sink   (input valid, input cmd, input offset, input write_data, output ready);
endinterface

interface ddct_out_if;
  logic                        valid;
  logic                        ready;
  logic [ddct_pkg::DATA_W-1:0] read_data;
  logic                        irq_zero;
  logic                        irq_one;
  logic                        irq_either;

  modport source (output valid, output read_data, output irq_zero, output irq_one,
                  output irq_either, input ready);
  modport sink   (input valid, input read_data, input irq_zero, input irq_one,
                  input irq_either, output ready);
endinterface

/* rtl/core/dual_down_counter_timer.sv */
// ----------------------------------------------------------------------------
// Dual down-counter timer
// Path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the receiver takes results; the timer state update is a single pass.
// Reset: asynchronous; counters all ones, control 0x20, everything else zero but the payload registers.
// ----------------------------------------------------------------------------
`include "dual_down_counter_timer_macros.svh"

module dual_down_counter_timer (
  input  logic       clk_i,
  input  logic       rst_ni,
  ddct_in_if.sink    in_i,
  ddct_out_if.source out_o
);
  import ddct_pkg::*;

  localparam int unsigned CW = COUNTER_WIDTH;

  // Low sixteen bits of the counter, used when the timer is in 16-bit mode.
  localparam logic [CW-1:0] MASK16 = CW'(32'h0000_FFFF);

  // --------------------------------------------------------------------------
  // Handshake and pipeline control.
  // Stage one holds the accepted item. The item is executed against the timer
  // state in the cycle it leaves stage one, and its result lands in the
  // output register. Stage one drains whenever the output register is empty
  // or is being emptied. While a result waits, a new item can still enter an
  // empty stage one; once stage one is occupied as well, the input stalls
  // until the waiting result is taken.
  // --------------------------------------------------------------------------
  logic      s1_valid_q;
  in_item_t  s1_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t out_d;

  logic s1_adv;
  logic in_accept;

  assign s1_adv    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.cmd        <= in_i.cmd;
      s1_q.offset     <= in_i.offset;
      s1_q.write_data <= in_i.write_data;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_data  = out_q.read_data;
  assign out_o.irq_zero   = out_q.irq_zero;
  assign out_o.irq_one    = out_q.irq_one;
  assign out_o.irq_either = out_q.irq_either;

  // --------------------------------------------------------------------------
  // Decode of the item in stage one.
  // --------------------------------------------------------------------------
  logic       sel;
  logic [2:0] reg_idx;

  assign sel     = s1_q.offset[TIMER_SEL_BIT];
  assign reg_idx = s1_q.offset[REG_MSB:REG_LSB];

  // --------------------------------------------------------------------------
  // Timer state, one set per timer.
  // --------------------------------------------------------------------------
  logic [CW-1:0]         reload_q [NUM_TIMERS];
  logic [CW-1:0]         reload_d [NUM_TIMERS];
  logic [CW-1:0]         count_q  [NUM_TIMERS];
  logic [CW-1:0]         count_d  [NUM_TIMERS];
  logic [CTRL_W-1:0]     ctrl_q   [NUM_TIMERS];
  logic [CTRL_W-1:0]     ctrl_d   [NUM_TIMERS];
  logic                  raw_q    [NUM_TIMERS];
  logic                  raw_d    [NUM_TIMERS];
  logic [PRESCALE_W-1:0] psc_q    [NUM_TIMERS];
  logic [PRESCALE_W-1:0] psc_d    [NUM_TIMERS];
  logic [DATA_W-1:0]     rd_t     [NUM_TIMERS];
  logic                  irq_d    [NUM_TIMERS];

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
    localparam logic TSEL = 1'(i);

    logic          hit;
    logic [CW-1:0] mask;
    logic [CW-1:0] cur;
    logic [CW-1:0] dec;
    logic [CW-1:0] rel;

    assign hit  = (sel == TSEL);
    assign mask = ctrl_q[i][CTL_SIZE32] ? {CW{1'b1}} : MASK16;
    assign cur  = count_q[i] & mask;
    assign dec  = cur - CW'(1);
    assign rel  = reload_q[i] & mask;

    // Next state for this timer.
    always_comb begin
      reload_d[i] = reload_q[i];
      count_d[i]  = count_q[i];
      ctrl_d[i]   = ctrl_q[i];
      raw_d[i]    = raw_q[i];
      psc_d[i]    = psc_q[i];
      case (s1_q.cmd)
        CMD_TICK: begin
          if (ctrl_q[i][CTL_ENABLE]) begin
            if (psc_q[i] < prescale_last(ctrl_q[i][CTL_PSC_MSB:CTL_PSC_LSB])) begin
              psc_d[i] = psc_q[i] + PRESCALE_W'(1);
            end else begin
              psc_d[i] = '0;
              if (cur != '0) begin
                // Count down; landing on zero raises the interrupt.
                count_d[i] = dec;
                if (dec == '0) begin
                  raw_d[i] = 1'b1;
                end
              end else if (ctrl_q[i][CTL_ONESHOT]) begin
                // A halted one-shot timer stays put and does not re-arm.
                count_d[i] = count_q[i];
              end else if (ctrl_q[i][CTL_PERIODIC]) begin
                count_d[i] = rel;
                if (rel == '0) begin
                  raw_d[i] = 1'b1;
                end
              end else begin
                // Free-running mode wraps to the largest count of its size.
                count_d[i] = mask;
              end
            end
          end
        end
        CMD_WRITE: begin
          if (hit) begin
            case (reg_idx)
              REG_LOAD: begin
                reload_d[i] = s1_q.write_data[CW-1:0];
                count_d[i]  = s1_q.write_data[CW-1:0];
                psc_d[i]    = '0;
              end
              REG_CONTROL: begin
                ctrl_d[i] = s1_q.write_data[CTRL_W-1:0] & CTL_WRITABLE;
              end
              REG_INTCLR: begin
                raw_d[i] = 1'b0;
              end
              REG_BGLOAD: begin
                reload_d[i] = s1_q.write_data[CW-1:0];
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    // Read data from this timer, zero when the item is not a read of it.
    always_comb begin
      rd_t[i] = '0;
      if ((s1_q.cmd == CMD_READ) && hit) begin
        case (reg_idx)
          REG_LOAD, REG_BGLOAD: rd_t[i] = DATA_W'(reload_q[i]);
          REG_VALUE:            rd_t[i] = DATA_W'(cur);
          REG_CONTROL:          rd_t[i] = DATA_W'(ctrl_q[i]);
          REG_RIS:              rd_t[i] = DATA_W'(raw_q[i]);
          REG_MIS:              rd_t[i] = DATA_W'(raw_q[i] & ctrl_q[i][CTL_IE]);
          default:              rd_t[i] = '0;
        endcase
      end
    end

    assign irq_d[i] = raw_d[i] & ctrl_d[i][CTL_IE];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        reload_q[i] <= '0;
        count_q[i]  <= {CW{1'b1}};
        ctrl_q[i]   <= CTL_RESET;
        raw_q[i]    <= 1'b0;
        psc_q[i]    <= '0;
      end else if (s1_adv) begin
        reload_q[i] <= reload_d[i];
        count_q[i]  <= count_d[i];
        ctrl_q[i]   <= ctrl_d[i];
        raw_q[i]    <= raw_d[i];
        psc_q[i]    <= psc_d[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result assembly. Only the addressed timer drives nonzero read data, so
  // the per-timer values are simply ORed. The interrupt outputs reflect the
  // state after this item has been applied.
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] rd_all;
  logic              irq_one_d;

  always_comb begin
    rd_all = '0;
    for (int unsigned k = 0; k < NUM_TIMERS; k++) begin
      rd_all = rd_all | rd_t[k];
    end
  end

  if (NUM_TIMERS > 1) begin : g_irq_one
    assign irq_one_d = irq_d[NUM_TIMERS-1];
  end else begin : g_no_irq_one
    assign irq_one_d = 1'b0;
  end

  always_comb begin
    out_d.read_data  = rd_all;
    out_d.irq_zero   = irq_d[0];
    out_d.irq_one    = irq_one_d;
    out_d.irq_either = irq_d[0] | irq_one_d;
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `DDCT_ASSERT_IMPLY(a_load_sets_count,
    s1_adv && (s1_q.cmd == CMD_WRITE) && (reg_idx == REG_LOAD) && (sel == 1'b0),
    ##1 (count_q[0] == $past(s1_q.write_data[CW-1:0])),
    "Load write did not set the timer zero count")
  `DDCT_ASSERT_IMPLY(a_state_holds_when_stalled, !s1_adv,
    ##1 ($stable(count_q[0]) && $stable(ctrl_q[0]) && $stable(raw_q[0])),
    "Timer state changed without an item being executed")
  `DDCT_ASSERT_ON(a_reserved_ctrl_bit_zero, ctrl_q[0][4] == 1'b0,
    "Reserved control bit became set")
  `DDCT_ASSERT_IMPLY(a_ready_when_empty, !out_valid_q, in_i.ready,
    "Input stalled although the result register is empty")

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Dual down-counter timer testbench
// Drives ticks, register reads and register writes through the command
// channel and checks every result item against a cycle-free timer model
// kept here. A short table of directed items comes first, then random
// timer programs run under three different patterns of sender and
// receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ddct_pkg::*;

  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned HOLD_CYCLES   = 64;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 640;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam int unsigned N_DIR         = 25;

  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam logic [2:0]       REG_UNMAPPED = 3'd7;
  localparam logic             TMR0         = 1'b0;
  localparam logic             TMR1         = 1'b1;

  localparam logic [DATA_W-1:0] CNT_MASK = DATA_W'((64'd1 << COUNTER_WIDTH) - 64'd1);

  logic clk;
  logic rst_n;

  ddct_in_if  cmd_ch ();
  ddct_out_if res_ch ();

  dual_down_counter_timer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  // Timer state as the checker sees it, updated once per accepted item.
  logic [DATA_W-1:0]     tmr_reload [2];
  logic [DATA_W-1:0]     tmr_count  [2];
  logic [CTRL_W-1:0]     tmr_ctrl   [2];
  logic                  tmr_raw    [2];
  logic [PRESCALE_W-1:0] tmr_psc    [2];

  out_item_t pending_results [$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_req;
  int unsigned err_cnt;
  int unsigned quiet_cycles;
  int unsigned n_sent;
  int unsigned n_ticks;
  int unsigned n_reads;
  int unsigned n_writes;
  int unsigned n_other;
  int unsigned n_irq_results;

  // The directed table. Rows with chk set carry a read value that follows
  // straight from reset or from the register map; all others rely on the
  // model below.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   wdata;
    logic                chk;
    logic [DATA_W-1:0]   rd;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    // Reset values: control 0x20 means 16-bit mode, so Value shows 0xFFFF.
    '{CMD_READ,   {TMR0, REG_CONTROL,  2'b00}, 32'h0,        1'b1, 32'h0000_0020},
    '{CMD_READ,   {TMR0, REG_VALUE,    2'b00}, 32'h0,        1'b1, 32'h0000_FFFF},
    '{CMD_READ,   {TMR1, REG_LOAD,     2'b00}, 32'h0,        1'b1, 32'h0},
    '{CMD_READ,   {TMR0, REG_MIS,      2'b00}, 32'h0,        1'b1, 32'h0},
    '{CMD_READ,   {TMR0, REG_UNMAPPED, 2'b00}, 32'h0,        1'b1, 32'h0},
    '{CMD_UNUSED, {TMR1, REG_LOAD,     2'b00}, 32'hFFFF_FFFF, 1'b1, 32'h0},
    // Timer zero: count of three, enabled, periodic, interrupt on, 32-bit.
    '{CMD_WRITE,  {TMR0, REG_LOAD,     2'b00}, 32'h3,        1'b1, 32'h0},
    '{CMD_WRITE,  {TMR0, REG_CONTROL,  2'b00}, 32'hE2,       1'b1, 32'h0},
    '{CMD_TICK,   {TMR0, REG_LOAD,     2'b00}, 32'h0,        1'b0, 32'h0},
    '{CMD_TICK,   6'h3F,                       32'hFFFF_FFFF, 1'b0, 32'h0},
    '{CMD_TICK,   {TMR0, REG_LOAD,     2'b00}, 32'h0,        1'b0, 32'h0},
    '{CMD_READ,   {TMR0, REG_RIS,      2'b11}, 32'h0,        1'b0, 32'h0},
    '{CMD_TICK,   {TMR0, REG_LOAD,     2'b00}, 32'h0,        1'b0, 32'h0},
    '{CMD_READ,   {TMR0, REG_VALUE,    2'b00}, 32'h0,        1'b0, 32'h0},
    '{CMD_WRITE,  {TMR0, REG_INTCLR,   2'b00}, 32'h0,        1'b0, 32'h0},
    // Timer one: every control bit set; the reserved bit reads back clear.
    '{CMD_WRITE,  {TMR1, REG_CONTROL,  2'b00}, 32'hFF,       1'b1, 32'h0},
    '{CMD_READ,   {TMR1, REG_CONTROL,  2'b00}, 32'h0,        1'b1, 32'h0000_00EF},
    '{CMD_WRITE,  {TMR1, REG_BGLOAD,   2'b00}, 32'hFFFF_FFFF, 1'b1, 32'h0},
    '{CMD_READ,   {TMR1, REG_BGLOAD,   2'b00}, 32'h0,        1'b1, 32'hFFFF_FFFF},
    // A one-shot timer loaded with zero must stay halted without an interrupt.
    '{CMD_WRITE,  {TMR1, REG_LOAD,     2'b00}, 32'h0,        1'b0, 32'h0},
    '{CMD_TICK,   {TMR1, REG_LOAD,     2'b00}, 32'h0,        1'b0, 32'h0},
    '{CMD_WRITE,  {TMR1, REG_VALUE,    2'b00}, 32'h1234_5678, 1'b0, 32'h0},
    // Disabled timer zero in /16 one-shot mode: ticks must leave it alone.
    '{CMD_WRITE,  {TMR0, REG_CONTROL,  2'b00}, 32'h25,       1'b0, 32'h0},
    '{CMD_READ,   {TMR1, REG_UNMAPPED, 2'b00}, 32'h0,        1'b1, 32'h0},
    '{CMD_TICK,   {TMR0, REG_LOAD,     2'b00}, 32'h0,        1'b0, 32'h0}
  };

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Counter mask for the current size mode of a timer.
  function automatic logic [DATA_W-1:0] count_mask(input int t);
    return tmr_ctrl[t][CTL_SIZE32] ? CNT_MASK : (CNT_MASK & 32'h0000_FFFF);
  endfunction

  // Applies one item to the timer state and returns the result it causes.
  function automatic out_item_t timer_step(input in_item_t it);
    out_item_t         res;
    logic              tsel;
    logic [2:0]        rsel;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] c;
    int                div;
    tsel = it.offset[TIMER_SEL_BIT];
    rsel = it.offset[REG_MSB:REG_LSB];
    res  = '0;
    if (it.cmd == CMD_TICK) begin
      for (int t = 0; t < int'(NUM_TIMERS); t++) begin
        if (tmr_ctrl[t][CTL_ENABLE]) begin
          m = count_mask(t);
          c = tmr_count[t] & m;
          case (tmr_ctrl[t][CTL_PSC_MSB:CTL_PSC_LSB])
            PSC_DIV16:  div = 16;
            PSC_DIV256: div = 256;
            default:    div = 1;
          endcase
          if (int'(tmr_psc[t]) + 1 < div) begin
            tmr_psc[t] = tmr_psc[t] + 1'b1;
          end else begin
            tmr_psc[t] = '0;
            if (c != 0) begin
              c = c - 1'b1;
              if (c == 0) tmr_raw[t] = 1'b1;
              tmr_count[t] = c;
            end else if (!tmr_ctrl[t][CTL_ONESHOT]) begin
              // Zero reached earlier: periodic reloads, free-running wraps.
              if (tmr_ctrl[t][CTL_PERIODIC]) begin
                c = tmr_reload[t] & m;
                if (c == 0) tmr_raw[t] = 1'b1;
              end else begin
                c = m;
              end
              tmr_count[t] = c;
            end
          end
        end
      end
    end else if (int'(tsel) < int'(NUM_TIMERS)) begin
      if (it.cmd == CMD_READ) begin
        case (rsel)
          REG_LOAD, REG_BGLOAD: res.read_data = tmr_reload[tsel];
          REG_VALUE:            res.read_data = tmr_count[tsel] & count_mask(tsel);
          REG_CONTROL:          res.read_data = DATA_W'(tmr_ctrl[tsel]);
          REG_RIS:              res.read_data = DATA_W'(tmr_raw[tsel]);
          REG_MIS:              res.read_data = DATA_W'(tmr_raw[tsel] & tmr_ctrl[tsel][CTL_IE]);
          default:              res.read_data = '0;
        endcase
      end else if (it.cmd == CMD_WRITE) begin
        case (rsel)
          REG_LOAD: begin
            tmr_reload[tsel] = it.write_data & CNT_MASK;
            tmr_count[tsel]  = it.write_data & CNT_MASK;
            tmr_psc[tsel]    = '0;
          end
          REG_CONTROL: tmr_ctrl[tsel]   = it.write_data[CTRL_W-1:0] & CTL_WRITABLE;
          REG_INTCLR:  tmr_raw[tsel]    = 1'b0;
          REG_BGLOAD:  tmr_reload[tsel] = it.write_data & CNT_MASK;
          default: ;
        endcase
      end
    end
    res.irq_zero   = tmr_raw[0] & tmr_ctrl[0][CTL_IE];
    res.irq_one    = (NUM_TIMERS > 1) && tmr_raw[1] && tmr_ctrl[1][CTL_IE];
    res.irq_either = res.irq_zero | res.irq_one;
    return res;
  endfunction

  // An item for one register of one timer; the ignored low offset bits are
  // randomized so that they toggle too.
  function automatic in_item_t reg_item(input logic [CMD_W-1:0] cmd, input logic tsel,
                                        input logic [2:0] rsel, input logic [DATA_W-1:0] wd);
    in_item_t it;
    it.cmd        = cmd;
    it.offset     = {tsel, rsel, 2'($urandom_range(3))};
    it.write_data = wd;
    return it;
  endfunction

  // Offers one item, idling before it at the sender's rate, and records the
  // expected result once the block takes it. A typed value, if given,
  // replaces the model's read data.
  task automatic send_item(input in_item_t it, input logic chk = 1'b0,
                           input logic [DATA_W-1:0] typed_rd = '0);
    out_item_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= it.cmd;
    cmd_ch.offset     <= it.offset;
    cmd_ch.write_data <= it.write_data;
    do @(posedge clk); while (!cmd_ch.ready);
    want = timer_step(it);
    if (chk) want.read_data = typed_rd;
    pending_results.push_back(want);
    n_sent++;
    case (it.cmd)
      CMD_TICK:  n_ticks++;
      CMD_READ:  n_reads++;
      CMD_WRITE: n_writes++;
      default:   n_other++;
    endcase
  endtask

  // Stops offering items and waits for every outstanding result.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // One timer program: load, configure, maybe a background load, then a run of
  // ticks mixed with reads, interrupt clears and the odd random item, then status reads.
  // The run of ticks is kept within the items left in the phase.
  task automatic run_timer_program(input int budget);
    logic              tsel;
    logic [1:0]        psc;
    logic [CTRL_W-1:0] ctl;
    logic [DATA_W-1:0] load;
    int                div;
    int                span;
    int unsigned       r;
    in_item_t          noise;
    tsel = 1'($urandom_range(1));
    case ($urandom_range(7))
      0:       psc = PSC_DIV256;
      1, 2:    psc = PSC_DIV16;
      3:       psc = 2'd3;
      default: psc = PSC_DIV1;
    endcase
    ctl = CTRL_W'($urandom());
    ctl[CTL_ENABLE]              = ($urandom_range(9) != 0);
    ctl[CTL_ONESHOT]             = ($urandom_range(3) == 0);
    ctl[CTL_PSC_MSB:CTL_PSC_LSB] = psc;
    div = (psc == PSC_DIV256) ? 256 : (psc == PSC_DIV16) ? 16 : 1;
    case ($urandom_range(9))
      0:       load = $urandom();
      1:       load = $urandom_range(32'hFFF0, 32'h1_0010);
      default: load = (div == 256) ? $urandom_range(1) : $urandom_range(12);
    endcase
    send_item(reg_item(CMD_WRITE, tsel, REG_LOAD, load));
    send_item(reg_item(CMD_WRITE, tsel, REG_CONTROL, {24'($urandom()), ctl}));
    if ($urandom_range(2) == 0)
      send_item(reg_item(CMD_WRITE, tsel, REG_BGLOAD, $urandom_range(6)));
    span = div * ((load > 20 ? 20 : int'(load)) + 2 + int'($urandom_range(3)));
    if (span > 600) span = 600;
    if (span > budget) span = budget;
    for (int i = 0; i < span; i++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_item(reg_item(CMD_READ, tsel, 3'($urandom_range(7)), $urandom()));
      end else if (r < 12) begin
        send_item(reg_item(CMD_WRITE, tsel, REG_INTCLR, $urandom()));
      end else if (r < 14) begin
        noise.cmd        = CMD_W'($urandom_range(3));
        noise.offset     = OFFSET_W'($urandom());
        noise.write_data = $urandom();
        send_item(noise);
      end else begin
        send_item(reg_item(CMD_TICK, 1'($urandom_range(1)), 3'($urandom_range(7)),
                           $urandom()));
      end
    end
    send_item(reg_item(CMD_READ, tsel, REG_RIS, '0));
    send_item(reg_item(CMD_READ, tsel, REG_MIS, '0));
    send_item(reg_item(CMD_READ, tsel, REG_VALUE, '0));
  endtask

  // Random part of one phase: mostly timer programs, some loose items.
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned stop_at;
    in_item_t    it;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      if ($urandom_range(4) != 0) begin
        run_timer_program(int'(stop_at - n_sent));
      end else begin
        it.cmd        = CMD_W'($urandom_range(3));
        it.offset     = OFFSET_W'($urandom());
        it.write_data = $urandom();
        send_item(it);
      end
    end
  endtask

  // Receiver: random back-pressure, or one long hold-off on request while
  // the sender keeps offering, so the block fills and stalls its input.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        for (int i = 0; i < int'(HOLD_CYCLES); i++) @(posedge clk);
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      if (err_cnt < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Result checking and the stall watchdog.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
                   $time, STALL_LIMIT, pending_results.size());
          $display("TB_ERROR");
          $finish;
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got read_data %h",
                     $time, res_ch.read_data);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("read_data",  want.read_data,          res_ch.read_data);
          check_field("irq_zero",   DATA_W'(want.irq_zero),  DATA_W'(res_ch.irq_zero));
          check_field("irq_one",    DATA_W'(want.irq_one),   DATA_W'(res_ch.irq_one));
          check_field("irq_either", DATA_W'(want.irq_either), DATA_W'(res_ch.irq_either));
          if (res_ch.irq_either === 1'b1) n_irq_results++;
        end
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.cmd        = '0;
    cmd_ch.offset     = '0;
    cmd_ch.write_data = '0;
    hold_req          = 1'b0;
    err_cnt           = 0;
    quiet_cycles      = 0;
    n_sent            = 0;
    n_ticks           = 0;
    n_reads           = 0;
    n_writes          = 0;
    n_other           = 0;
    n_irq_results     = 0;
    // First phase: the sender idles a little, the receiver a lot.
    tx_idle_pct       = 24;
    rx_idle_pct       = 61;
    for (int t = 0; t < 2; t++) begin
      tmr_reload[t] = '0;
      tmr_count[t]  = CNT_MASK;
      tmr_ctrl[t]   = CTL_RESET;
      tmr_raw[t]    = 1'b0;
      tmr_psc[t]    = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < int'(N_DIR); i++)
      send_item('{dir_rows[i].cmd, dir_rows[i].offset, dir_rows[i].wdata},
                dir_rows[i].chk, dir_rows[i].rd);
    drain_results();
    run_random_phase(PHASE_ITEMS);
    drain_results();

    // Second phase: the idling pattern the other way round.
    tx_idle_pct = 61;
    rx_idle_pct = 24;
    run_random_phase(PHASE_ITEMS);
    drain_results();

    // Last phase: no idling, opened by a long receiver hold-off.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    run_random_phase(PHASE_ITEMS);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d items: %0d ticks, %0d reads, %0d writes, %0d unused commands.",
             n_sent, n_ticks, n_reads, n_writes, n_other);
    $display("%0d results showed a pending interrupt; %0d mismatches found.",
             n_irq_results, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
